// ----- sv/buddy_block_allocator_macros.svh -----
// Assertion helpers for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Codes and sequencer states shared by the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // command codes
    localparam logic [1:0] FN_INIT  = 2'd0;
    localparam logic [1:0] FN_ALLOC = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;
    localparam logic [1:0] FN_QUERY = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_BAD_CFG    = 3'd1;
    localparam logic [2:0] STAT_TOO_LARGE  = 3'd2;
    localparam logic [2:0] STAT_NO_BLOCK   = 3'd3;
    localparam logic [2:0] STAT_OUTSIDE    = 3'd4;
    localparam logic [2:0] STAT_ALREADY    = 3'd5;
    localparam logic [2:0] STAT_NOT_ALLOC  = 3'd6;
    localparam logic [2:0] STAT_MISALIGNED = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_POOL_SIZE = 2'd0;
    localparam logic [1:0] REG_MIN_LEVEL = 2'd1;
    localparam logic [1:0] REG_MAX_LEVEL = 2'd2;

    localparam logic [16:0] POOL_SIZE_RST = 17'd4096;
    localparam logic [4:0]  MIN_LEVEL_RST = 5'd4;
    localparam logic [4:0]  MAX_LEVEL_RST = 5'd12;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_CLR,
        ST_INIT_SEED,
        ST_A_LEV,
        ST_A_SRCH,
        ST_A_TOP,
        ST_A_SPLIT,
        ST_A_PUSH1,
        ST_A_PUSH2,
        ST_A_FIN,
        ST_L_ITER,
        ST_L_BUSY,
        ST_L_DONE,
        ST_F_CHK,
        ST_F_LOOP,
        ST_F_LF,
        ST_F_RM2,
        ST_F_MERGE,
        ST_F_END,
        ST_F_END2,
        ST_FIND,
        ST_RMCHK,
        ST_SHIFT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator with per-level LIFO free lists and per-pair busy bits,
// both held in synchronous RAMs and updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel   | ports                                         | direction
//  ----------+-----------------------------------------------+----------
//  command   | i_start, o_busy, i_func, i_request_size,      | in
//            | i_block_offset                                |
//  result    | o_done, o_status, o_result_offset,            | out
//            | o_block_size                                  |
//  config    | i_cfg_we, i_cfg_idx, i_cfg_wdata              | in
//
// One transaction at a time; o_busy stays high until its result strobe.
// Init sweeps all 2^(LEVEL_COUNT-1) busy bits, then seeds the lists block by
// block, stepping down one level at a time until each block fits.
// Allocate, free and query walk the levels one at a time and scan or shift
// the free-list entries one at a time through the free-list RAM.
// Failures caught up front answer straight from idle, without going busy.
// Reset needs no sweep: nothing is read before a successful init.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none

`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
    parameter int POOL_BITS   = 16,
    parameter int LEVEL_COUNT = 13
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [16:0] i_request_size,
    input  wire logic [15:0] i_block_offset,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [15:0]      o_result_offset,
    output logic [16:0]      o_block_size,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_wdata
);

    localparam int PB    = POOL_BITS;
    localparam int LC    = LEVEL_COUNT;
    localparam int FLOOR = PB - LC + 1;
    localparam int SA    = LC;
    localparam int SD    = 2 ** LC;
    localparam int BA    = (LC > 1) ? LC - 1 : 1;
    localparam int BD    = 2 ** (LC - 1);
    localparam int CW    = LC;
    localparam int CIW   = (LC > 1) ? $clog2(LC) : 1;
    localparam int LW    = $clog2(PB + 2);
    localparam int AW    = ((PB > 17) ? PB : 17) + 2;

    function automatic logic [AW-1:0] f_pw(input logic [LW-1:0] e);
        f_pw = AW'(1) << e;
    endfunction

    function automatic logic [SA-1:0] f_base(input logic [LW-1:0] e);
        logic [SA:0] t;
        t = ((SA+1)'(1) << (LW'(PB) - e)) - (SA+1)'(1);
        f_base = t[SA-1:0];
    endfunction

    function automatic logic [CW-1:0] f_cap(input logic [LW-1:0] e);
        f_cap = CW'(1) << (LW'(PB) - e);
    endfunction

    function automatic logic [BA-1:0] f_bidx(input logic [LW-1:0] e,
                                             input logic [AW-1:0] off);
        logic [AW-1:0] t;
        if (e >= LW'(PB)) begin
            t = '0;
        end else begin
            t = (AW'(1) << (LW'(PB - 1) - e)) + (off >> (e + LW'(1)));
        end
        t = t & AW'(BD - 1);
        f_bidx = t[BA-1:0];
    endfunction

    function automatic logic [CIW-1:0] f_cidx(input logic [LW-1:0] e);
        f_cidx = CIW'(int'(e) - FLOOR);
    endfunction

    // memories
    logic [PB-1:0] store_mem [0:SD-1];
    logic          busy_mem  [0:BD-1];

    bba_pkg::t_state r_state, n_state, r_ret, n_ret, r_rret, n_rret;

    logic [16:0]   r_cfg_pool;
    logic [4:0]    r_cfg_min, r_cfg_max;
    logic          r_live, n_live;
    logic [AW-1:0] r_eff, n_eff;
    logic [LW-1:0] r_amin, n_amin, r_amax, n_amax;
    logic [1:0]    r_func, n_func;
    logic [AW-1:0] r_off, n_off, r_req, n_req, r_blk, n_blk;
    logic [LW-1:0] r_e, n_e, r_f, n_f, r_g, n_g;
    logic [BA-1:0] r_clr, n_clr;
    logic [LW-1:0] r_flev, n_flev;
    logic [AW-1:0] r_fkey, n_fkey;
    logic [CW-1:0] r_k, n_k, r_pk, n_pk, r_fk, n_fk;
    logic          r_pend, n_pend, r_found, n_found;
    logic          r_done, n_done;
    logic [2:0]    r_status, n_status;
    logic [15:0]   r_roff, n_roff;
    logic [16:0]   r_bsize, n_bsize;
    logic [CW-1:0] r_cnt [0:LC-1];
    logic [PB-1:0] r_srd;
    logic          r_brd;

    logic [LW-1:0] lev_sel;
    logic [CW-1:0] cnt_cur;
    logic          push_ok;
    logic [SA-1:0] push_addr;
    logic          s_we;
    logic [SA-1:0] s_waddr, s_raddr;
    logic [PB-1:0] s_wdata;
    logic          b_we, b_wdata;
    logic [BA-1:0] b_waddr, b_raddr;
    logic          cnt_inc, cnt_dec, cnt_clr;
    logic          cfg_ok;
    logic [AW-1:0] cap_top, cap_size, init_size;
    logic [AW-1:0] boff, merged, seed_rem;
    logic [AW-1:0] pw_e;
    logic          issue, hit;

    always_comb begin
        case (r_state)
            bba_pkg::ST_INIT_SEED, bba_pkg::ST_F_CHK: lev_sel = r_e;
            bba_pkg::ST_A_SRCH:                       lev_sel = r_f;
            bba_pkg::ST_A_PUSH1, bba_pkg::ST_A_PUSH2: lev_sel = r_g - LW'(1);
            bba_pkg::ST_F_MERGE:                      lev_sel = r_g + LW'(1);
            default:                                  lev_sel = r_flev;
        endcase
    end

    assign cnt_cur   = r_cnt[f_cidx(lev_sel)];
    assign push_ok   = cnt_cur < f_cap(lev_sel);
    assign push_addr = f_base(lev_sel) + cnt_cur;

    assign cfg_ok = (int'(r_cfg_min) >= FLOOR) && (int'(r_cfg_max) <= PB)
                    && (r_cfg_max >= r_cfg_min);
    assign cap_top   = AW'(1) << r_cfg_max;
    assign cap_size  = (AW'(r_cfg_pool) > cap_top) ? cap_top : AW'(r_cfg_pool);
    assign init_size = cap_size & ~((AW'(1) << r_cfg_min) - AW'(1));

    assign boff     = r_blk ^ f_pw(r_g);
    assign merged   = r_blk & ~f_pw(r_g);
    assign seed_rem = r_eff - r_off;
    assign pw_e     = f_pw(r_e);
    assign hit      = r_pend && (AW'(r_srd) == r_fkey);

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_rret   = r_rret;
        n_live   = r_live;
        n_eff    = r_eff;
        n_amin   = r_amin;
        n_amax   = r_amax;
        n_func   = r_func;
        n_off    = r_off;
        n_req    = r_req;
        n_blk    = r_blk;
        n_e      = r_e;
        n_f      = r_f;
        n_g      = r_g;
        n_clr    = r_clr;
        n_flev   = r_flev;
        n_fkey   = r_fkey;
        n_k      = r_k;
        n_pk     = r_pk;
        n_fk     = r_fk;
        n_pend   = r_pend;
        n_found  = r_found;
        n_done   = 1'b0;
        n_status = r_status;
        n_roff   = r_roff;
        n_bsize  = r_bsize;
        s_we     = 1'b0;
        s_waddr  = push_addr;
        s_wdata  = '0;
        s_raddr  = f_base(r_flev) + r_k;
        b_we     = 1'b0;
        b_waddr  = f_bidx(r_g, r_blk);
        b_wdata  = 1'b0;
        b_raddr  = f_bidx(r_e, r_off);
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        cnt_clr  = 1'b0;
        issue    = 1'b0;

        case (r_state)
            bba_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_func   = i_func;
                    n_req    = AW'(i_request_size);
                    n_off    = AW'(i_block_offset);
                    n_status = bba_pkg::STAT_OK;
                    n_roff   = '0;
                    n_bsize  = '0;
                    if (i_func == bba_pkg::FN_INIT) begin
                        n_live  = 1'b0;
                        n_eff   = '0;
                        cnt_clr = 1'b1;
                        n_clr   = '0;
                        n_state = bba_pkg::ST_INIT_CLR;
                    end else if (!r_live) begin
                        n_done   = 1'b1;
                        n_status = bba_pkg::STAT_BAD_CFG;
                    end else if (i_func == bba_pkg::FN_ALLOC) begin
                        if (AW'(i_request_size) > f_pw(r_amax)) begin
                            n_done   = 1'b1;
                            n_status = bba_pkg::STAT_TOO_LARGE;
                        end else begin
                            n_e     = r_amin;
                            n_state = bba_pkg::ST_A_LEV;
                        end
                    end else begin
                        if (AW'(i_block_offset) >= r_eff) begin
                            n_done   = 1'b1;
                            n_status = bba_pkg::STAT_OUTSIDE;
                        end else begin
                            n_e     = r_amin;
                            n_state = bba_pkg::ST_L_ITER;
                        end
                    end
                end
            end

            bba_pkg::ST_INIT_CLR: begin
                b_we    = 1'b1;
                b_waddr = r_clr;
                n_clr   = r_clr + BA'(1);
                if (r_clr == BA'(BD - 1)) begin
                    if (!cfg_ok || init_size == '0) begin
                        n_done   = 1'b1;
                        n_status = bba_pkg::STAT_BAD_CFG;
                        n_state  = bba_pkg::ST_IDLE;
                    end else begin
                        n_live  = 1'b1;
                        n_eff   = init_size;
                        n_amin  = LW'(r_cfg_min);
                        n_amax  = LW'(r_cfg_max);
                        n_e     = LW'(r_cfg_max);
                        n_off   = '0;
                        n_state = bba_pkg::ST_INIT_SEED;
                    end
                end
            end

            bba_pkg::ST_INIT_SEED: begin
                if (r_off >= r_eff) begin
                    n_done  = 1'b1;
                    n_state = bba_pkg::ST_IDLE;
                end else if (r_e > r_amin && f_pw(r_e) > seed_rem) begin
                    n_e = r_e - LW'(1);
                end else begin
                    s_we    = push_ok;
                    s_wdata = r_off[PB-1:0];
                    cnt_inc = push_ok;
                    n_off   = r_off + f_pw(r_e);
                    n_e     = r_amax;
                end
            end

            bba_pkg::ST_A_LEV: begin
                if (f_pw(r_e) < r_req) begin
                    n_e = r_e + LW'(1);
                end else begin
                    n_f     = r_e;
                    n_state = bba_pkg::ST_A_SRCH;
                end
            end

            bba_pkg::ST_A_SRCH: begin
                if (r_f > r_amax) begin
                    n_done   = 1'b1;
                    n_status = bba_pkg::STAT_NO_BLOCK;
                    n_state  = bba_pkg::ST_IDLE;
                end else if (cnt_cur != '0) begin
                    s_raddr = f_base(r_f) + cnt_cur - SA'(1);
                    n_state = bba_pkg::ST_A_TOP;
                end else begin
                    n_f = r_f + LW'(1);
                end
            end

            bba_pkg::ST_A_TOP: begin
                n_blk   = AW'(r_srd);
                n_g     = r_f;
                n_state = bba_pkg::ST_A_SPLIT;
            end

            bba_pkg::ST_A_SPLIT: begin
                n_fkey  = r_blk;
                n_k     = '0;
                n_pend  = 1'b0;
                n_ret   = bba_pkg::ST_RMCHK;
                n_state = bba_pkg::ST_FIND;
                if (r_g > r_e) begin
                    n_flev = r_g;
                    n_rret = bba_pkg::ST_A_PUSH1;
                end else begin
                    n_flev = r_e;
                    n_rret = bba_pkg::ST_A_FIN;
                end
            end

            bba_pkg::ST_A_PUSH1: begin
                s_we    = push_ok;
                s_wdata = PB'(r_blk | f_pw(r_g - LW'(1)));
                cnt_inc = push_ok;
                n_state = bba_pkg::ST_A_PUSH2;
            end

            bba_pkg::ST_A_PUSH2: begin
                s_we    = push_ok;
                s_wdata = r_blk[PB-1:0];
                cnt_inc = push_ok;
                b_we    = 1'b1;
                b_wdata = 1'b1;
                n_g     = r_g - LW'(1);
                n_state = bba_pkg::ST_A_SPLIT;
            end

            bba_pkg::ST_A_FIN: begin
                b_we    = 1'b1;
                b_waddr = f_bidx(r_e, r_blk);
                b_wdata = 1'b1;
                n_done  = 1'b1;
                n_roff  = r_blk[15:0];
                n_bsize = pw_e[16:0];
                n_state = bba_pkg::ST_IDLE;
            end

            bba_pkg::ST_L_ITER: begin
                if (r_e > r_amax) begin
                    n_done   = 1'b1;
                    n_status = bba_pkg::STAT_NOT_ALLOC;
                    n_state  = bba_pkg::ST_IDLE;
                end else if ((r_eff >> r_e) == '0) begin
                    n_e = r_e + LW'(1);
                end else begin
                    n_state = bba_pkg::ST_L_BUSY;
                end
            end

            bba_pkg::ST_L_BUSY: begin
                if (!r_brd) begin
                    n_e     = r_e + LW'(1);
                    n_state = bba_pkg::ST_L_ITER;
                end else begin
                    n_flev  = r_e;
                    n_fkey  = r_off & ~(f_pw(r_e) - AW'(1));
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_ret   = bba_pkg::ST_L_DONE;
                    n_state = bba_pkg::ST_FIND;
                end
            end

            bba_pkg::ST_L_DONE: begin
                if (r_found) begin
                    n_done   = 1'b1;
                    n_status = bba_pkg::STAT_ALREADY;
                    n_state  = bba_pkg::ST_IDLE;
                end else if (r_func == bba_pkg::FN_QUERY) begin
                    n_done   = 1'b1;
                    n_bsize  = pw_e[16:0];
                    n_state  = bba_pkg::ST_IDLE;
                end else begin
                    n_state = bba_pkg::ST_F_CHK;
                end
            end

            bba_pkg::ST_F_CHK: begin
                if (r_off + f_pw(r_e) > r_eff) begin
                    n_done   = 1'b1;
                    n_status = bba_pkg::STAT_OUTSIDE;
                    n_state  = bba_pkg::ST_IDLE;
                end else if ((r_off & (f_pw(r_e) - AW'(1))) != '0) begin
                    n_done   = 1'b1;
                    n_status = bba_pkg::STAT_MISALIGNED;
                    n_state  = bba_pkg::ST_IDLE;
                end else begin
                    s_we    = push_ok;
                    s_wdata = r_off[PB-1:0];
                    cnt_inc = push_ok;
                    n_g     = r_e;
                    n_blk   = r_off;
                    n_state = bba_pkg::ST_F_LOOP;
                end
            end

            bba_pkg::ST_F_LOOP: begin
                if (r_g < r_amax && boff + f_pw(r_g) <= r_eff) begin
                    n_flev  = r_g;
                    n_fkey  = boff;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_ret   = bba_pkg::ST_F_LF;
                    n_state = bba_pkg::ST_FIND;
                end else begin
                    n_state = bba_pkg::ST_F_END;
                end
            end

            bba_pkg::ST_F_LF: begin
                if (!r_found) begin
                    n_state = bba_pkg::ST_F_END;
                end else begin
                    n_flev  = r_g;
                    n_fkey  = r_blk;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_ret   = bba_pkg::ST_RMCHK;
                    n_rret  = bba_pkg::ST_F_RM2;
                    n_state = bba_pkg::ST_FIND;
                end
            end

            bba_pkg::ST_F_RM2: begin
                n_flev  = r_g;
                n_fkey  = boff;
                n_k     = '0;
                n_pend  = 1'b0;
                n_ret   = bba_pkg::ST_RMCHK;
                n_rret  = bba_pkg::ST_F_MERGE;
                n_state = bba_pkg::ST_FIND;
            end

            bba_pkg::ST_F_MERGE: begin
                b_we    = 1'b1;
                b_wdata = 1'b0;
                s_we    = push_ok;
                s_wdata = merged[PB-1:0];
                cnt_inc = push_ok;
                n_blk   = merged;
                n_g     = r_g + LW'(1);
                n_state = bba_pkg::ST_F_LOOP;
            end

            bba_pkg::ST_F_END: begin
                if (boff + f_pw(r_g) > r_eff) begin
                    b_we    = 1'b1;
                    n_done  = 1'b1;
                    n_state = bba_pkg::ST_IDLE;
                end else if (r_g == r_amax) begin
                    n_flev  = r_g;
                    n_fkey  = boff;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_ret   = bba_pkg::ST_F_END2;
                    n_state = bba_pkg::ST_FIND;
                end else begin
                    n_done  = 1'b1;
                    n_state = bba_pkg::ST_IDLE;
                end
            end

            bba_pkg::ST_F_END2: begin
                b_we    = r_found;
                n_done  = 1'b1;
                n_state = bba_pkg::ST_IDLE;
            end

            // linear scan, one read issued per cycle, compared against the registered read data
            bba_pkg::ST_FIND: begin
                issue = !hit && (r_k < cnt_cur);
                if (hit) begin
                    n_found = 1'b1;
                    n_fk    = r_pk;
                    n_pend  = 1'b0;
                    n_state = r_ret;
                end else if (!issue && !r_pend) begin
                    n_found = 1'b0;
                    n_state = r_ret;
                end else begin
                    n_pend = issue;
                    if (issue) begin
                        n_pk = r_k;
                        n_k  = r_k + CW'(1);
                    end
                end
            end

            bba_pkg::ST_RMCHK: begin
                if (!r_found) begin
                    n_state = r_rret;
                end else begin
                    n_k     = r_fk + CW'(1);
                    n_pend  = 1'b0;
                    n_state = bba_pkg::ST_SHIFT;
                end
            end

            // close the gap: read entry k, write it back one place lower
            bba_pkg::ST_SHIFT: begin
                issue = r_k < cnt_cur;
                if (r_pend) begin
                    s_we    = 1'b1;
                    s_waddr = f_base(r_flev) + r_pk - SA'(1);
                    s_wdata = r_srd;
                end
                n_pend = issue;
                if (issue) begin
                    n_pk = r_k;
                    n_k  = r_k + CW'(1);
                end else if (!r_pend) begin
                    cnt_dec = 1'b1;
                    n_state = r_rret;
                end
            end

            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            store_mem[s_waddr] <= s_wdata;
        end
        r_srd <= store_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            busy_mem[b_waddr] <= b_wdata;
        end
        r_brd <= busy_mem[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LC; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (cnt_clr) begin
            for (int i = 0; i < LC; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (cnt_inc) begin
            r_cnt[f_cidx(lev_sel)] <= cnt_cur + CW'(1);
        end else if (cnt_dec) begin
            r_cnt[f_cidx(lev_sel)] <= cnt_cur - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bba_pkg::ST_IDLE;
            r_live     <= 1'b0;
            r_eff      <= '0;
            r_done     <= 1'b0;
            r_cfg_pool <= bba_pkg::POOL_SIZE_RST;
            r_cfg_min  <= bba_pkg::MIN_LEVEL_RST;
            r_cfg_max  <= bba_pkg::MAX_LEVEL_RST;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_eff   <= n_eff;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bba_pkg::REG_POOL_SIZE: r_cfg_pool <= i_cfg_wdata;
                    bba_pkg::REG_MIN_LEVEL: r_cfg_min  <= i_cfg_wdata[4:0];
                    bba_pkg::REG_MAX_LEVEL: r_cfg_max  <= i_cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_rret   <= n_rret;
        r_amin   <= n_amin;
        r_amax   <= n_amax;
        r_func   <= n_func;
        r_off    <= n_off;
        r_req    <= n_req;
        r_blk    <= n_blk;
        r_e      <= n_e;
        r_f      <= n_f;
        r_g      <= n_g;
        r_clr    <= n_clr;
        r_flev   <= n_flev;
        r_fkey   <= n_fkey;
        r_k      <= n_k;
        r_pk     <= n_pk;
        r_fk     <= n_fk;
        r_pend   <= n_pend;
        r_found  <= n_found;
        r_status <= n_status;
        r_roff   <= n_roff;
        r_bsize  <= n_bsize;
    end

    assign o_busy          = (r_state != bba_pkg::ST_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_result_offset = r_roff;
    assign o_block_size    = r_bsize;

    `BBA_ASSERT_NOW(a_err_fields_zero, i_clk, i_rst_n,
        o_done && (o_status != bba_pkg::STAT_OK),
        (o_result_offset == 16'd0) && (o_block_size == 17'd0),
        "error result carries a non-zero offset or size")
    `BBA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, i_start && !o_busy,
        o_busy || o_done, "accepted transaction neither in flight nor answered")
    `BBA_ASSERT_NOW(a_shift_after_hit, i_clk, i_rst_n,
        r_state == bba_pkg::ST_SHIFT, r_found,
        "list shift entered without a matching entry")
    `BBA_ASSERT_NOW(a_busy_write_idle, i_clk, i_rst_n,
        r_state == bba_pkg::ST_IDLE, !b_we && !s_we,
        "memory written while idle")

endmodule

`default_nettype wire
